// ===== rtl/a2b_pkg.sv =====
// ----------------------------------------------------------------------------
// a2b_pkg
// Shared types and constants for the AVCC to Annex B byte stream converter.
// ----------------------------------------------------------------------------
package a2b_pkg;

	// Parser phase, one-hot
	typedef enum logic [6:0] {
		PH_SKIP     = 7'b000_0001,
		PH_LEN      = 7'b000_0010,
		PH_UNIT     = 7'b000_0100,
		PH_PPS_CNT  = 7'b000_1000,
		PH_DONE     = 7'b001_0000,
		PH_LEN_PPS  = 7'b010_0000,
		PH_UNIT_PPS = 7'b100_0000
	} phase_t;

	// Tag body constants
	localparam logic [7:0]  KEYFRAME_TAG    = 8'h17;
	localparam logic [3:0]  HDR_PREFIX_LAST = 4'd4;   // last byte of the 5-byte prefix
	localparam logic [3:0]  SPS_COUNT_OFS   = 4'd10;  // offset of the SPS count byte
	localparam logic [3:0]  OFFSET_MAX      = 4'd15;
	localparam logic [31:0] NAL_SYNC        = 32'h0000_0001;

	// Results of one input byte: an optional copied byte, then an optional start code
	typedef struct packed {
		logic       has_data;
		logic       has_start;
		logic [7:0] data;
		logic       keyframe;
		logic       truncated;
	} run_t;

	// Byte k (0..3) of the start code
	function automatic logic [7:0] start_byte(input logic [1:0] k);
		logic [7:0] b;
		case (k)
			2'd0:    b = NAL_SYNC[31:24];
			2'd1:    b = NAL_SYNC[23:16];
			2'd2:    b = NAL_SYNC[15:8];
			default: b = NAL_SYNC[7:0];
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/a2b_in_if.sv =====
// ----------------------------------------------------------------------------
// a2b_in_if
// Valid/ready channel carrying one video tag body byte per transaction.
// ----------------------------------------------------------------------------
interface a2b_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] body_byte;
	logic       first_of_packet;
	logic       last_of_packet;

	modport source (output valid, body_byte, first_of_packet, last_of_packet, input ready);
	modport sink   (input valid, body_byte, first_of_packet, last_of_packet, output ready);
endinterface

// ===== rtl/a2b_out_if.sv =====
// ----------------------------------------------------------------------------
// a2b_out_if
// Valid/ready channel carrying one Annex B stream byte per transaction.
// ----------------------------------------------------------------------------
interface a2b_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       keyframe;
	logic       truncated;

	modport source (output valid, out_byte, last_of_run, keyframe, truncated, input ready);
	modport sink   (input valid, out_byte, last_of_run, keyframe, truncated, output ready);
endinterface

// ===== rtl/a2b_parser.sv =====
// ----------------------------------------------------------------------------
// a2b_parser
// Tag body parser: tracks header/NAL framing and decides, per byte, which
// bytes go to the output stream.
// ----------------------------------------------------------------------------
module a2b_parser
	import a2b_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	a2b_in_if.sink    body,
	input  logic      run_free,
	output logic      run_load,
	output run_t      run_next
);

	logic        header_seen_q;
	phase_t      phase_q;
	logic [3:0]  byte_offset_q;
	logic [4:0]  sets_left_q;
	logic [31:0] length_accum_q;
	logic [1:0]  length_bytes_seen_q;
	logic [31:0] unit_bytes_left_q;
	logic        key_flag_q;

	logic        hs;
	phase_t      ph;
	logic [3:0]  off;
	logic [4:0]  sl;
	logic [31:0] acc;
	logic [1:0]  lbs;
	logic [31:0] ubl;
	logic        kf;
	logic        in_prog;
	logic        unit_done;
	logic        emit_data;
	logic        emit_start;
	logic        trunc;
	logic        fire;

	assign body.ready = run_free;
	assign fire       = body.valid && run_free;

	// Next state and results for the byte on the channel
	always_comb begin
		hs         = header_seen_q;
		ph         = phase_q;
		off        = byte_offset_q;
		sl         = sets_left_q;
		acc        = length_accum_q;
		lbs        = length_bytes_seen_q;
		ubl        = unit_bytes_left_q;
		kf         = key_flag_q;
		unit_done  = 1'b0;
		emit_data  = 1'b0;
		emit_start = 1'b0;
		trunc      = 1'b0;
		in_prog    = !(phase_q == PH_SKIP && byte_offset_q == '0);

		// new packet; a packet in progress counts as the header if it was one
		if (body.first_of_packet) begin
			if (in_prog) hs = 1'b1;
			ph  = PH_SKIP;
			off = '0;
			acc = '0;
			lbs = '0;
			ubl = '0;
		end

		unique case (ph) inside
			PH_SKIP: begin
				if (off == '0) begin
					kf = (body.body_byte == KEYFRAME_TAG);
					if (!hs) emit_start = 1'b1;
				end
				if (hs && off == HDR_PREFIX_LAST) begin
					ph  = PH_LEN;
					acc = '0;
					lbs = '0;
				end else if (!hs && off == SPS_COUNT_OFS) begin
					sl = body.body_byte[4:0];
					if (sl == '0) begin
						ph = PH_PPS_CNT;
					end else begin
						ph  = PH_LEN;
						acc = '0;
						lbs = '0;
					end
				end
			end
			PH_LEN, PH_LEN_PPS: begin
				acc = {acc[23:0], body.body_byte};
				if (lbs == (hs ? 2'd3 : 2'd1)) begin
					ubl = acc;
					lbs = '0;
					ph  = (ph == PH_LEN) ? PH_UNIT : PH_UNIT_PPS;
					if (ubl == '0) unit_done = 1'b1;
				end else begin
					lbs = lbs + 2'd1;
				end
			end
			PH_UNIT, PH_UNIT_PPS: begin
				emit_data = 1'b1;
				ubl       = ubl - 32'd1;
				if (ubl == '0) unit_done = 1'b1;
			end
			PH_PPS_CNT: begin
				sl = body.body_byte[4:0];
				if (sl == '0) begin
					ph = PH_DONE;
				end else begin
					ph  = PH_LEN_PPS;
					acc = '0;
					lbs = '0;
				end
			end
			default: ;
		endcase

		// unit fully copied: start code, then next length, next list or done
		if (unit_done) begin
			emit_start = 1'b1;
			if (ph == PH_UNIT && hs) begin
				ph  = PH_LEN;
				acc = '0;
				lbs = '0;
			end else if (ph == PH_UNIT) begin
				sl = sl - 5'd1;
				if (sl == '0) begin
					ph = PH_PPS_CNT;
				end else begin
					ph  = PH_LEN;
					acc = '0;
					lbs = '0;
				end
			end else begin
				sl = sl - 5'd1;
				if (sl == '0) begin
					ph = PH_DONE;
				end else begin
					ph  = PH_LEN_PPS;
					acc = '0;
					lbs = '0;
				end
			end
		end

		if (off < OFFSET_MAX) off = off + 4'd1;

		// end of packet; close an open unit with a start code
		if (body.last_of_packet) begin
			if (ph == PH_UNIT || ph == PH_UNIT_PPS) begin
				emit_start = 1'b1;
				trunc      = 1'b1;
			end
			hs  = 1'b1;
			ph  = PH_SKIP;
			off = '0;
			acc = '0;
			lbs = '0;
			ubl = '0;
		end
	end

	assign run_next.has_data  = emit_data;
	assign run_next.has_start = emit_start;
	assign run_next.data      = body.body_byte;
	assign run_next.keyframe  = kf;
	assign run_next.truncated = trunc;
	assign run_load           = fire && (emit_data || emit_start);

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_seen_q       <= 1'b0;
			phase_q             <= PH_SKIP;
			byte_offset_q       <= '0;
			sets_left_q         <= '0;
			length_accum_q      <= '0;
			length_bytes_seen_q <= '0;
			unit_bytes_left_q   <= '0;
			key_flag_q          <= 1'b0;
		end else if (fire) begin
			header_seen_q       <= hs;
			phase_q             <= ph;
			byte_offset_q       <= off;
			sets_left_q         <= sl;
			length_accum_q      <= acc;
			length_bytes_seen_q <= lbs;
			unit_bytes_left_q   <= ubl;
			key_flag_q          <= kf;
		end
	end

endmodule

// ===== rtl/a2b_serializer.sv =====
// ----------------------------------------------------------------------------
// a2b_serializer
// Holds the results of one input byte and sends them out one per transaction.
// ----------------------------------------------------------------------------
module a2b_serializer
	import a2b_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      run_load,
	input  run_t      run_next,
	output logic      run_free,
	a2b_out_if.source annexb
);

	run_t       run_s1;
	logic       run_valid_s1;
	logic [2:0] idx_q;
	logic [2:0] count;
	logic [2:0] start_pos;
	logic       is_last;
	logic       out_fire;

	// results in this run: optional data byte, then four start code bytes if has_start
	assign count     = {run_s1.has_start, 2'b00} + {2'b00, run_s1.has_data};
	assign is_last   = (idx_q == count - 3'd1);
	assign start_pos = idx_q - {2'b00, run_s1.has_data};
	assign out_fire  = annexb.valid && annexb.ready;

	assign annexb.valid       = run_valid_s1;
	assign annexb.out_byte    = (run_s1.has_data && idx_q == '0) ? run_s1.data
	                                                           : start_byte(start_pos[1:0]);
	assign annexb.last_of_run = is_last;
	assign annexb.keyframe    = run_s1.keyframe;
	assign annexb.truncated   = run_s1.truncated;

	// free now, or freed by the last byte leaving this cycle
	assign run_free = !run_valid_s1 || (annexb.ready && is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_s1 <= 1'b0;
			idx_q        <= '0;
		end else if (run_load) begin
			run_valid_s1 <= 1'b1;
			idx_q        <= '0;
		end else if (out_fire) begin
			if (is_last) run_valid_s1 <= 1'b0;
			idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
		end
	end

	// Run payload
	always_ff @(posedge clk) begin
		if (run_load) run_s1 <= run_next;
	end

endmodule

// ===== rtl/avcc_to_annexb_converter.sv =====
// ----------------------------------------------------------------------------
// avcc_to_annexb_converter
// Converts H.264 video tag bodies in AVCC form into an Annex B byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   body   : input channel, one tag body byte per transaction, with marks for
//            the first and last byte of each body.
//   annexb : output channel, one Annex B byte per transaction; last_of_run
//            marks the final byte produced by one body byte.
//   The first body after reset is taken as the decoder configuration record;
//   its parameter sets are copied, each preceded/followed by a start code.
//   Later bodies carry 4-byte length-prefixed NAL units.
// Timing:
//   Results of a body byte appear in the cycle after it is taken; one giving
//   no output or a single byte does not hold off the next one while the
//   receiver is ready. One adding a start code holds the output until all its
//   bytes leave, and the next body byte is taken in the cycle the last leaves.
//   The single result register between parser and output sets this.
// Reset: arst_n clears all framing state; the next body is the header again.
// Stall: when the receiver deasserts ready the result register holds and the
//   input is held off once it is still occupied.
// ----------------------------------------------------------------------------
module avcc_to_annexb_converter
	import a2b_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	a2b_in_if.sink    body,
	a2b_out_if.source annexb
);

	logic run_free;
	logic run_load;
	run_t run_next;

	a2b_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.body     (body),
		.run_free (run_free),
		.run_load (run_load),
		.run_next (run_next)
	);

	a2b_serializer u_serializer (
		.clk      (clk),
		.arst_n   (arst_n),
		.run_load (run_load),
		.run_next (run_next),
		.run_free (run_free),
		.annexb   (annexb)
	);

endmodule
